// File: sv/srd_pkg.sv
// shared types, codes and constants of the stepper ramp reversing driver
`timescale 1ns / 1ps

package srd_pkg;

    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned SCALED_W   = 19;  // p*6 of a 16-bit period
    localparam int unsigned RECIP_W    = 19;
    localparam int unsigned RECIP_SH   = 21;
    localparam int unsigned QUOT_W     = 17;  // floor(p*6/5) of a 16-bit period

    // reciprocals ceil(2^21/6) and ceil(2^21/5), exact for dividends below 2^19
    localparam logic [RECIP_W-1:0] RECIP_DIV6 = 19'd349526;
    localparam logic [RECIP_W-1:0] RECIP_DIV5 = 19'd419431;

    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd1000;
    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 16'd20;
    localparam logic [PERIOD_W-1:0] TICK_MAX        = 16'hFFFF;

    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_PERIOD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_PERIOD = 1'd1;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_CW      = 2'd1,
        MODE_CCW     = 2'd2
    } mode_t;

    typedef enum logic {
        ACT_TICK   = 1'b0,
        ACT_BUTTON = 1'b1
    } action_t;

    typedef struct packed {
        action_t action;
        logic    gate_pin;
    } item_t;

    typedef struct packed {
        logic                slowing;
        logic                reverse;
        logic [PERIOD_W-1:0] period;
    } ramp_res_t;

    typedef struct packed {
        logic       slowing;
        logic [1:0] run_mode;
        logic       stepped;
        logic [3:0] coil_drive;
    } result_t;

    function automatic logic [3:0] phase_pattern(input logic [1:0] idx);
        logic [3:0] pat;
        unique case (idx)
            2'd0: pat = 4'b0101;
            2'd1: pat = 4'b0110;
            2'd2: pat = 4'b1010;
            2'd3: pat = 4'b1001;
            default: pat = 4'b0101;
        endcase
        return pat;
    endfunction

endpackage

// File: sv/srd_ramp.sv
// period ramp: scale by 5/6 or 6/5 and clamp to the fast and slow limits
`timescale 1ns / 1ps

module srd_ramp (
    input  logic [srd_pkg::PERIOD_W-1:0] period,
    input  logic                         slowing,
    input  logic [srd_pkg::PERIOD_W-1:0] slow_period,
    input  logic [srd_pkg::PERIOD_W-1:0] fast_period,
    output srd_pkg::ramp_res_t           ramp
);
    import srd_pkg::*;

    logic [SCALED_W-1:0]         scaled;
    logic [RECIP_W-1:0]          recip;
    logic [SCALED_W+RECIP_W-1:0] product;
    logic [QUOT_W-1:0]           quot;
    logic [QUOT_W-1:0]           clamped;
    logic                        slow_fast;

    // p*5 when speeding up, p*6 when slowing, then divide by 6 or 5
    assign scaled = slowing
        ? ({1'b0, period, 2'b00} + {2'b00, period, 1'b0})
        : ({1'b0, period, 2'b00} + {3'b000, period});
    assign recip   = slowing ? RECIP_DIV5 : RECIP_DIV6;
    assign product = {{RECIP_W{1'b0}}, scaled} * {{SCALED_W{1'b0}}, recip};
    assign quot    = product[RECIP_SH +: QUOT_W];

    always_comb begin
        clamped   = quot;
        slow_fast = slowing;
        ramp.reverse = 1'b0;
        if (clamped <= {1'b0, fast_period}) begin
            clamped   = {1'b0, fast_period};
            slow_fast = 1'b1;
        end
        if (clamped > {1'b0, slow_period}) begin
            clamped      = {1'b0, slow_period};
            slow_fast    = 1'b0;
            ramp.reverse = 1'b1;
        end
        ramp.period  = clamped[PERIOD_W-1:0];
        ramp.slowing = slow_fast;
    end

endmodule

// File: sv/srd_core.sv
// motor state registers and the per-transaction update of tick count, ramp and phase
`timescale 1ns / 1ps

module srd_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         item_en,
    input  srd_pkg::item_t               item,
    input  logic [srd_pkg::PERIOD_W-1:0] slow_period,
    input  logic [srd_pkg::PERIOD_W-1:0] fast_period,
    output srd_pkg::result_t             result
);
    import srd_pkg::*;

    logic [PERIOD_W-1:0] tick_count_reg, tick_count_next;
    logic [PERIOD_W-1:0] step_period_reg, step_period_next;
    logic [1:0]          phase_reg, phase_next;
    mode_t               mode_reg, mode_next;
    logic                slowing_reg, slowing_next;
    logic [3:0]          coil_reg, coil_next;
    logic                stepped;
    ramp_res_t           ramp;

    srd_ramp u_ramp (
        .period      (step_period_reg),
        .slowing     (slowing_reg),
        .slow_period (slow_period),
        .fast_period (fast_period),
        .ramp        (ramp)
    );

    always_comb begin
        logic [PERIOD_W-1:0] tick_inc;
        mode_t               mode_run;
        tick_inc         = (tick_count_reg == TICK_MAX) ? tick_count_reg
                                                        : tick_count_reg + 1'b1;
        tick_count_next  = tick_count_reg;
        step_period_next = step_period_reg;
        phase_next       = phase_reg;
        mode_next        = mode_reg;
        slowing_next     = slowing_reg;
        coil_next        = coil_reg;
        stepped          = 1'b0;
        mode_run         = mode_reg;
        unique case (item.action)
            ACT_TICK: begin
                tick_count_next = tick_inc;
                if (tick_inc >= step_period_reg) begin
                    tick_count_next = '0;
                    if (mode_reg != MODE_STOPPED) begin
                        step_period_next = ramp.period;
                        slowing_next     = ramp.slowing;
                        if (ramp.reverse) begin
                            mode_run = (mode_reg == MODE_CW) ? MODE_CCW : MODE_CW;
                        end
                    end
                    mode_next = mode_run;
                    if (mode_run == MODE_CW || mode_run == MODE_CCW) begin
                        coil_next  = phase_pattern(phase_reg);
                        phase_next = (mode_run == MODE_CW) ? phase_reg + 2'd1
                                                           : phase_reg - 2'd1;
                        stepped    = 1'b1;
                    end
                end
            end
            ACT_BUTTON: begin
                if (!item.gate_pin) begin
                    if (mode_reg == MODE_STOPPED) begin
                        mode_next = MODE_CW;
                    end else begin
                        mode_next        = MODE_STOPPED;
                        slowing_next     = 1'b0;
                        step_period_next = slow_period;
                    end
                end
            end
            default: ;
        endcase
    end

    assign result.coil_drive = coil_next;
    assign result.stepped    = stepped;
    assign result.run_mode   = mode_next;
    assign result.slowing    = slowing_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            step_period_reg <= SLOW_PERIOD_RST;
            phase_reg       <= '0;
            mode_reg        <= MODE_STOPPED;
            slowing_reg     <= 1'b0;
            coil_reg        <= '0;
        end else if (item_en) begin
            tick_count_reg  <= tick_count_next;
            step_period_reg <= step_period_next;
            phase_reg       <= phase_next;
            mode_reg        <= mode_next;
            slowing_reg     <= slowing_next;
            coil_reg        <= coil_next;
        end
    end

endmodule

// File: sv/stepper_ramp_reversing_driver.sv
// top level of the stepper ramp reversing driver: stream ports, config registers, result register
`timescale 1ns / 1ps

// Full-step driver for a four-coil stepper. Each input transaction is a timer tick
// (s_tuser = 0) or a start/stop button event (s_tuser = 1, acting only while the gate
// pin in s_tdata[0] is low). Ticks are counted; when the count reaches the step period
// the period of a running motor ramps (x5/6 speeding up, x6/5 slowing, clamped to
// fast_period and slow_period, reversing direction at the slow end) and it takes one
// step. Every input transaction gives exactly one result transaction. One transaction
// is accepted per clock unless the result stream stalls: the state update (tick
// compare, one constant-reciprocal multiply for the ramp, clamp and phase step) is
// combinational and the result is registered. The result register lets a new input in
// while the previous result is being taken. Config registers are written through
// cfg_wr_en / cfg_addr / cfg_wr_data while the block is idle (the user's duty, not
// enforced); a new slow_period reaches the step period only on a stop or a clamp.

module stepper_ramp_reversing_driver (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [0] gate_pin, [7:1] zero
    input  logic [0:0]                       s_tuser,   // [0] action
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [3:0] coil_drive, [4] stepped,
                                                        // [6:5] run_mode, [7] slowing
    // config write port
    input  logic                             cfg_wr_en,
    input  logic [srd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [srd_pkg::PERIOD_W-1:0]     cfg_wr_data
);
    import srd_pkg::*;

    logic [PERIOD_W-1:0] slow_period_reg;
    logic [PERIOD_W-1:0] fast_period_reg;
    logic                m_valid_reg, m_valid_next;
    result_t             m_data_reg;
    result_t             result;
    item_t               item;
    logic                accept;

    // take a new transaction whenever the result register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign item.action   = action_t'(s_tuser[0]);
    assign item.gate_pin = s_tdata[0];

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_period_reg <= SLOW_PERIOD_RST;
            fast_period_reg <= FAST_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SLOW_PERIOD: slow_period_reg <= cfg_wr_data;
                CFG_FAST_PERIOD: fast_period_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // motor state and per-transaction update
    srd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_en     (accept),
        .item        (item),
        .slow_period (slow_period_reg),
        .fast_period (fast_period_reg),
        .result      (result)
    );

    // result register
    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // an accepted transaction always shows up in the result register next cycle
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted transaction did not reach the result register");

    // a button event never produces a step
    a_button_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser[0]) |=> !m_data_reg.stepped)
        else $error("button event reported a step");

    // a step is only reported while the motor runs
    a_step_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.stepped) |->
            (m_data_reg.run_mode == MODE_CW || m_data_reg.run_mode == MODE_CCW))
        else $error("step reported with the motor stopped");

    // without a step the coil pattern holds across consecutive transactions
    a_coil_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && $past(accept) && !result.stepped && $past(aresetn)) |=>
            (m_data_reg.coil_drive == $past(m_data_reg.coil_drive)))
        else $error("coil pattern changed without a step");
`endif

endmodule
